[rtl/pha_pkg.sv]
// shared types, constants and helpers for the pi heading aligner
package pha_pkg;

  localparam int unsigned ErrW    = 14;
  localparam int unsigned GainW   = 16;
  localparam int unsigned ILimW   = 20;
  localparam int unsigned SpdW    = 15;
  localparam int unsigned SeekW   = 2;
  localparam int unsigned IntegW  = 22;
  localparam int unsigned DriveW  = 16;
  localparam int unsigned AddrW   = 3;
  localparam int unsigned CfgDataW = 20;
  localparam int unsigned ProdShift = 5;

  // register indexes on the configuration port
  localparam logic [AddrW-1:0] RegPropGain  = 3'd0;
  localparam logic [AddrW-1:0] RegIntegGain = 3'd1;
  localparam logic [AddrW-1:0] RegIntegLim  = 3'd2;
  localparam logic [AddrW-1:0] RegSpeedLim  = 3'd3;
  localparam logic [AddrW-1:0] RegSeekDir   = 3'd4;

  // seek direction codes, anything else means no rotation
  localparam logic [SeekW-1:0] SeekLeft  = 2'd0;
  localparam logic [SeekW-1:0] SeekRight = 2'd1;
  localparam logic [SeekW-1:0] SeekNone  = 2'd2;

  // 0.2 in q1.15, rounded to nearest
  localparam logic signed [DriveW-1:0] SeekValue = 16'sd6554;

  localparam logic [SpdW-1:0] SpeedLimReset = 15'd16384;

  typedef struct packed {
    logic signed [GainW-1:0] prop_gain;
    logic signed [GainW-1:0] integ_gain;
    logic [ILimW-1:0]        integ_limit;
    logic [SpdW-1:0]         speed_limit;
    logic [SeekW-1:0]        seek_direction;
  } cfg_t;

  // clamp a 17 bit signed value to +/- lim
  function automatic logic signed [DriveW-1:0] clamp_drive(
    input logic signed [DriveW:0] v,
    input logic [SpdW-1:0]        lim
  );
    logic signed [DriveW:0] hi;
    logic signed [DriveW:0] lo;
    logic signed [DriveW:0] r;
    hi = $signed({2'b00, lim});
    lo = -hi;
    if (v > hi) begin
      r = hi;
    end else if (v < lo) begin
      r = lo;
    end else begin
      r = v;
    end
    return r[DriveW-1:0];
  endfunction

endpackage

[rtl/pha_steer_calc.sv]
// steering datapath: pi products, shift, saturation and wheel clamps
module pha_steer_calc (
  input  pha_pkg::cfg_t                               cfg_i,
  input  logic signed [pha_pkg::ErrW-1:0]             err_i,
  input  logic signed [pha_pkg::IntegW-1:0]           integ_i,
  input  logic                                        target_i,
  output logic signed [pha_pkg::DriveW-1:0]           left_o,
  output logic signed [pha_pkg::DriveW-1:0]           right_o,
  output logic signed [pha_pkg::DriveW-1:0]           steer_o,
  output logic                                        aligned_o
);
  import pha_pkg::*;

  localparam int unsigned PPropW = GainW + ErrW;
  localparam int unsigned PIntW  = GainW + IntegW;
  localparam int unsigned AccW   = PIntW + 1;
  localparam int unsigned ShW    = AccW - ProdShift;

  logic signed [PPropW-1:0] prop_prod;
  logic signed [PIntW-1:0]  integ_prod;
  logic signed [AccW-1:0]   acc;
  logic signed [AccW-1:0]   acc_sh;
  logic signed [ShW-1:0]    shifted;
  logic signed [DriveW-1:0] pi_steer;
  logic signed [DriveW-1:0] steer;
  logic signed [DriveW:0]   steer_x;

  localparam logic signed [ShW-1:0] SatHi = ShW'(32767);
  localparam logic signed [ShW-1:0] SatLo = -ShW'(32768);

  always_comb begin
    prop_prod  = cfg_i.prop_gain * err_i;
    integ_prod = cfg_i.integ_gain * integ_i;
    acc = {{(AccW-PPropW){prop_prod[PPropW-1]}}, prop_prod}
        + {integ_prod[PIntW-1], integ_prod};
    acc_sh  = acc >>> ProdShift;
    shifted = acc_sh[ShW-1:0];
    if (shifted > SatHi) begin
      pi_steer = 16'sh7fff;
    end else if (shifted < SatLo) begin
      pi_steer = 16'sh8000;
    end else begin
      pi_steer = shifted[DriveW-1:0];
    end

    if (target_i) begin
      steer = pi_steer;
    end else if (cfg_i.seek_direction == SeekLeft) begin
      steer = SeekValue;
    end else if (cfg_i.seek_direction == SeekRight) begin
      steer = -SeekValue;
    end else begin
      // no rotation, also for the unused code
      steer = '0;
    end

    steer_x   = {steer[DriveW-1], steer};
    left_o    = clamp_drive(-steer_x, cfg_i.speed_limit);
    right_o   = clamp_drive(steer_x, cfg_i.speed_limit);
    steer_o   = steer;
    aligned_o = target_i && (left_o == '0) && (right_o == '0);
  end

endmodule

[rtl/pi_heading_aligner_top.sv]
// pi heading aligner top: config registers, integral, two stage pipeline
//
//  channel | direction | handshake             | payload
//  in      | sink      | in_valid_i/in_ready_o | heading_error_i, target_valid_i
//  out     | source    | out_valid_o/out_ready_i | left_drive_o, right_drive_o,
//          |           |                       | steer_value_o, aligned_o
//  cfg     | sink      | cfg_we_i              | cfg_addr_i, cfg_wdata_i
//
// one transaction per cycle sustained while the output is not stalled
// the integral is clamped and updated in the accept cycle, the products,
// shift, saturation and wheel clamps sit between the stage register and
// the output register
// reset clears the integral and valid bits and sets the config registers to their defaults
// a stalled output holds the stage register, input ready drops once both fill
module pi_heading_aligner_top (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [pha_pkg::AddrW-1:0]           cfg_addr_i,
  input  logic [pha_pkg::CfgDataW-1:0]        cfg_wdata_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [pha_pkg::ErrW-1:0]     heading_error_i,
  input  logic                                target_valid_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [pha_pkg::DriveW-1:0]   left_drive_o,
  output logic signed [pha_pkg::DriveW-1:0]   right_drive_o,
  output logic signed [pha_pkg::DriveW-1:0]   steer_value_o,
  output logic                                aligned_o
);
  import pha_pkg::*;

  cfg_t cfg_q;

  logic signed [IntegW-1:0] integ_q, integ_d;
  logic signed [IntegW:0]   sum_x, lim_x;

  logic                     s1_valid_q;
  logic signed [ErrW-1:0]   s1_err_q;
  logic signed [IntegW-1:0] s1_integ_q;
  logic                     s1_target_q;

  logic                     out_valid_q;
  logic signed [DriveW-1:0] left_q, right_q, steer_q;
  logic                     aligned_q;

  logic signed [DriveW-1:0] left_d, right_d, steer_d;
  logic                     aligned_d;

  logic in_acc, s1_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.prop_gain      <= '0;
      cfg_q.integ_gain     <= '0;
      cfg_q.integ_limit    <= '0;
      cfg_q.speed_limit    <= SpeedLimReset;
      cfg_q.seek_direction <= SeekNone;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        RegPropGain:  cfg_q.prop_gain      <= $signed(cfg_wdata_i[GainW-1:0]);
        RegIntegGain: cfg_q.integ_gain     <= $signed(cfg_wdata_i[GainW-1:0]);
        RegIntegLim:  cfg_q.integ_limit    <= cfg_wdata_i[ILimW-1:0];
        RegSpeedLim:  cfg_q.speed_limit    <= cfg_wdata_i[SpdW-1:0];
        RegSeekDir:   cfg_q.seek_direction <= cfg_wdata_i[SeekW-1:0];
        default: ;
      endcase
    end
  end

  assign s1_adv     = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_adv;
  assign in_acc     = in_valid_i && in_ready_o;

  // integral add and clamp to +/- limit, cleared without a target
  always_comb begin
    sum_x = {integ_q[IntegW-1], integ_q}
          + {{(IntegW+1-ErrW){heading_error_i[ErrW-1]}}, heading_error_i};
    lim_x = $signed({{(IntegW+1-ILimW){1'b0}}, cfg_q.integ_limit});
    if (!target_valid_i) begin
      integ_d = '0;
    end else if (sum_x > lim_x) begin
      integ_d = lim_x[IntegW-1:0];
    end else if (sum_x < -lim_x) begin
      integ_d = -lim_x[IntegW-1:0];
    end else begin
      integ_d = sum_x[IntegW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      integ_q    <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      if (in_acc) begin
        integ_q <= integ_d;
      end
      if (in_acc) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_err_q    <= heading_error_i;
      s1_integ_q  <= integ_d;
      s1_target_q <= target_valid_i;
    end
  end

  pha_steer_calc u_calc (
    .cfg_i     (cfg_q),
    .err_i     (s1_err_q),
    .integ_i   (s1_integ_q),
    .target_i  (s1_target_q),
    .left_o    (left_d),
    .right_o   (right_d),
    .steer_o   (steer_d),
    .aligned_o (aligned_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      left_q    <= left_d;
      right_q   <= right_d;
      steer_q   <= steer_d;
      aligned_q <= aligned_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign left_drive_o  = left_q;
  assign right_drive_o = right_q;
  assign steer_value_o = steer_q;
  assign aligned_o     = aligned_q;

  // a transaction without target clears the integral
  a_integ_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && !target_valid_i |=> integ_q == '0)
    else $error("integral not cleared after a no-target transaction");

  // a loaded stage with room downstream moves into the output register
  a_stage_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && (!out_valid_q || out_ready_i) |=> out_valid_q)
    else $error("stage transaction lost");

  // aligned only ever reported with both wheel commands at zero
  a_aligned_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && aligned_o |-> left_drive_o == '0 && right_drive_o == '0)
    else $error("aligned with nonzero drive");

endmodule

[verif/tb_pi_heading_aligner_top.sv]
// self-checking testbench for the pi heading aligner top level
module tb_pi_heading_aligner_top;
  timeunit 1ns;
  timeprecision 1ps;

  import pha_pkg::*;

  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned ReportLimit = 10;
  localparam int unsigned PhaseCount  = 10;
  localparam int unsigned PhaseItems  = 105;

  // seek code with no meaning of its own, behaves like no rotation
  localparam logic [SeekW-1:0] SeekSpare = 2'd3;
  // indexes past the register map
  localparam logic [AddrW-1:0] RegUnmappedLo = 3'd5;
  localparam logic [AddrW-1:0] RegUnmappedHi = 3'd7;

  typedef enum int {RdyAlways, RdyPattern, RdyRandom} rdy_style_e;

  typedef struct packed {
    logic signed [DriveW-1:0] left;
    logic signed [DriveW-1:0] right;
    logic signed [DriveW-1:0] steer;
    logic                     aligned;
  } wheel_cmd_t;

  logic                     clk_i       = 1'b0;
  logic                     rst_ni      = 1'b0;
  logic                     cfg_we      = 1'b0;
  logic [AddrW-1:0]         cfg_addr    = '0;
  logic [CfgDataW-1:0]      cfg_wdata   = '0;
  logic                     in_valid    = 1'b0;
  logic                     in_ready;
  logic signed [ErrW-1:0]   heading_err = '0;
  logic                     tgt_valid   = 1'b0;
  logic                     out_valid;
  logic                     out_ready   = 1'b0;
  logic signed [DriveW-1:0] left_drive;
  logic signed [DriveW-1:0] right_drive;
  logic signed [DriveW-1:0] steer_value;
  logic                     aligned;

  // controller mirror: register copy and running integral
  cfg_t                     wheel_cfg;
  logic signed [IntegW-1:0] integ_m = '0;

  wheel_cmd_t  expected_cmds[$];
  int unsigned mismatch_count = 0;
  int unsigned cycle_count    = 0;
  rdy_style_e  rdy_style      = RdyAlways;
  int unsigned hold_off_req   = 0;
  int unsigned gap_max        = 0;
  int unsigned burst_left     = 0;
  logic [15:0] rdy_pattern    = 16'hB5E3;

  pi_heading_aligner_top u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_addr_i      (cfg_addr),
    .cfg_wdata_i     (cfg_wdata),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready),
    .heading_error_i (heading_err),
    .target_valid_i  (tgt_valid),
    .out_valid_o     (out_valid),
    .out_ready_i     (out_ready),
    .left_drive_o    (left_drive),
    .right_drive_o   (right_drive),
    .steer_value_o   (steer_value),
    .aligned_o       (aligned)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic longint clamp_to(input longint v, input longint lo, input longint hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // next wheel commands for one camera sample, advances the integral
  function automatic wheel_cmd_t predict_wheel_cmd(input logic signed [ErrW-1:0] err,
                                                   input logic tgt);
    longint     sum;
    longint     acc;
    longint     steer;
    longint     lim;
    longint     ilim;
    longint     lft;
    longint     rgt;
    wheel_cmd_t c;
    lim  = longint'(wheel_cfg.speed_limit);
    ilim = longint'(wheel_cfg.integ_limit);
    if (!tgt) begin
      case (wheel_cfg.seek_direction)
        SeekLeft:  steer = longint'(SeekValue);
        SeekRight: steer = -longint'(SeekValue);
        default:   steer = 0;
      endcase
      integ_m = '0;
    end else begin
      sum = clamp_to(longint'(integ_m) + longint'(err), -ilim, ilim);
      integ_m = IntegW'(sum);
      acc = longint'(wheel_cfg.prop_gain) * longint'(err)
          + longint'(wheel_cfg.integ_gain) * sum;
      steer = clamp_to(acc >>> ProdShift, -32768, 32767);
    end
    lft = clamp_to(-steer, -lim, lim);
    rgt = clamp_to(steer, -lim, lim);
    c.left    = DriveW'(lft);
    c.right   = DriveW'(rgt);
    c.steer   = DriveW'(steer);
    c.aligned = tgt && (lft == 0) && (rgt == 0);
    return c;
  endfunction

  // one register write, with cfg_we dropped again before the task returns
  task automatic write_reg(input logic [AddrW-1:0] idx, input logic [CfgDataW-1:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    case (idx)
      RegPropGain:  wheel_cfg.prop_gain      = val[GainW-1:0];
      RegIntegGain: wheel_cfg.integ_gain     = val[GainW-1:0];
      RegIntegLim:  wheel_cfg.integ_limit    = val[ILimW-1:0];
      RegSpeedLim:  wheel_cfg.speed_limit    = val[SpdW-1:0];
      RegSeekDir:   wheel_cfg.seek_direction = val[SeekW-1:0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic send_sample(input logic signed [ErrW-1:0] e, input logic tv);
    in_valid    <= 1'b1;
    heading_err <= e;
    tgt_valid   <= tv;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
    expected_cmds = {expected_cmds, predict_wheel_cmd(e, tv)};
  endtask

  // bursty sender: random gap once a burst runs out
  task automatic feed_sample(input logic signed [ErrW-1:0] e, input logic tv);
    if (gap_max != 0) begin
      if (burst_left == 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, gap_max)) @(posedge clk_i);
        burst_left = $urandom_range(1, 24);
      end
      burst_left--;
    end
    send_sample(e, tv);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_cmds.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic test_reset_defaults();
    rdy_style = RdyRandom;
    feed_sample('0, 1'b0);
    feed_sample(14'sd8191, 1'b1);
    feed_sample(-14'sd8192, 1'b1);
    wait_drained();
  endtask

  task automatic test_seek_modes();
    write_reg(RegSeekDir, CfgDataW'(SeekLeft));
    feed_sample(-14'sd8192, 1'b0);
    wait_drained();
    write_reg(RegSeekDir, CfgDataW'(SeekRight));
    feed_sample(14'sd8191, 1'b0);
    wait_drained();
    write_reg(RegSeekDir, CfgDataW'(SeekSpare));
    feed_sample(14'sd77, 1'b0);
    wait_drained();
    // seek value beyond the wheel clamp
    write_reg(RegSeekDir, CfgDataW'(SeekLeft));
    write_reg(RegSpeedLim, 20'd100);
    feed_sample(14'sd5, 1'b0);
    wait_drained();
    // zero commands without a target must not flag aligned
    write_reg(RegSpeedLim, 20'd0);
    feed_sample('0, 1'b0);
    wait_drained();
  endtask

  task automatic test_saturation();
    // upper data bits carry junk that the registers drop
    write_reg(RegPropGain, 20'hF8000);
    write_reg(RegIntegGain, 20'hA8000);
    write_reg(RegIntegLim, 20'hFFFFF);
    write_reg(RegSpeedLim, 20'hF7FFF);
    write_reg(RegSeekDir, CfgDataW'(SeekNone));
    feed_sample(-14'sd8192, 1'b1);
    feed_sample(14'sd8191, 1'b1);
    feed_sample(14'sd8191, 1'b1);
    wait_drained();
    write_reg(RegPropGain, 20'h57FFF);
    write_reg(RegIntegGain, 20'h07FFF);
    feed_sample(-14'sd8192, 1'b1);
    wait_drained();
  endtask

  task automatic test_integral_clamp();
    write_reg(RegPropGain, 20'd0);
    write_reg(RegIntegGain, 20'h01000);
    write_reg(RegIntegLim, 20'd100);
    feed_sample(14'sd8191, 1'b1);
    feed_sample(14'sd8191, 1'b1);
    feed_sample(-14'sd8191, 1'b1);
    feed_sample(14'sd5, 1'b0);
    feed_sample(14'sd3, 1'b1);
    wait_drained();
  endtask

  task automatic test_floor_shift();
    write_reg(RegPropGain, 20'd1);
    write_reg(RegIntegGain, 20'd0);
    write_reg(RegIntegLim, 20'd0);
    write_reg(RegSpeedLim, CfgDataW'(SpeedLimReset));
    feed_sample(-14'sd1, 1'b1);
    feed_sample(14'sd31, 1'b1);
    feed_sample(14'sd32, 1'b1);
    feed_sample(-14'sd32, 1'b1);
    feed_sample(-14'sd33, 1'b1);
    wait_drained();
  endtask

  task automatic test_unmapped_writes();
    for (int i = RegUnmappedLo; i <= RegUnmappedHi; i++) begin
      write_reg(AddrW'(i), 20'hFFFFF);
    end
    feed_sample(14'sd100, 1'b1);
    feed_sample(-14'sd100, 1'b0);
    wait_drained();
  endtask

  // receiver holds off while the sender keeps offering
  task automatic test_backpressure();
    rdy_style    = RdyAlways;
    gap_max      = 0;
    hold_off_req = 400;
    for (int i = 0; i < 48; i++) begin
      feed_sample(ErrW'($urandom()), 1'($urandom_range(0, 3) != 0));
    end
    wait_drained();
  endtask

  function automatic logic [CfgDataW-1:0] pick_gain();
    logic [GainW-1:0] g;
    case ($urandom_range(0, 3))
      0:       g = GainW'($urandom());
      1:       g = GainW'(int'($urandom_range(0, 4096)) - 2048);
      2:       g = GainW'(int'($urandom_range(0, 256)) - 128);
      default: g = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
    endcase
    return {(CfgDataW-GainW)'($urandom()), g};
  endfunction

  task automatic test_random_phases();
    int                     remaining;
    int                     run;
    int                     e_cur;
    logic signed [ErrW-1:0] e_raw;
    for (int ph = 0; ph < PhaseCount; ph++) begin
      if (ph == 0) begin
        write_reg(RegPropGain, 20'h07FFF);
        write_reg(RegIntegGain, 20'h07FFF);
        write_reg(RegIntegLim, 20'hFFFFF);
        write_reg(RegSpeedLim, 20'h07FFF);
      end else if (ph == 1) begin
        write_reg(RegPropGain, 20'h08000);
        write_reg(RegIntegGain, 20'h08000);
        write_reg(RegIntegLim, 20'd0);
        write_reg(RegSpeedLim, 20'd0);
      end else begin
        write_reg(RegPropGain, pick_gain());
        write_reg(RegIntegGain, pick_gain());
        case ($urandom_range(0, 3))
          0:       write_reg(RegIntegLim, 20'hFFFFF);
          1:       write_reg(RegIntegLim, CfgDataW'($urandom()));
          default: write_reg(RegIntegLim, CfgDataW'($urandom_range(0, 20000)));
        endcase
        case ($urandom_range(0, 3))
          0:       write_reg(RegSpeedLim, {5'($urandom()), 15'h7FFF});
          1:       write_reg(RegSpeedLim, {5'($urandom()), 15'd0});
          default: write_reg(RegSpeedLim, {5'($urandom()), 15'($urandom())});
        endcase
      end
      write_reg(RegSeekDir, {18'($urandom()), SeekW'($urandom_range(0, 3))});
      rdy_style  = rdy_style_e'(ph % 3);
      gap_max    = (ph % 4 == 1) ? 0 : $urandom_range(1, 8);
      burst_left = 0;
      remaining  = PhaseItems;
      while (remaining > 0) begin
        case ($urandom_range(0, 9))
          0: begin
            // noise
            feed_sample(ErrW'($urandom()), 1'($urandom()));
            remaining--;
          end
          1: begin
            // target lost for a few samples
            run = $urandom_range(1, 6);
            for (int k = 0; k < run && remaining > 0; k++) begin
              feed_sample(ErrW'($urandom()), 1'b0);
              remaining--;
            end
          end
          default: begin
            // tracking run, error decays toward zero as the robot turns
            e_raw = ErrW'($urandom());
            e_cur = $urandom_range(0, 1) ? int'(e_raw) : int'($urandom_range(0, 2000)) - 1000;
            run = $urandom_range(1, 30);
            for (int k = 0; k < run && remaining > 0; k++) begin
              feed_sample(ErrW'(e_cur), 1'b1);
              remaining--;
              e_cur = int'(clamp_to(e_cur - e_cur / 4 + int'($urandom_range(0, 64)) - 32,
                                    -8192, 8191));
            end
          end
        endcase
      end
      wait_drained();
    end
  endtask

  // result checker
  always @(posedge clk_i) begin : check_results
    wheel_cmd_t exp_c;
    if (rst_ni && out_valid && out_ready) begin
      if (expected_cmds.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= ReportLimit) begin
          $display("unexpected result L=%0d R=%0d S=%0d A=%0b",
                   left_drive, right_drive, steer_value, aligned);
        end
      end else begin
        exp_c = expected_cmds.pop_front();
        if (exp_c.left !== left_drive || exp_c.right !== right_drive ||
            exp_c.steer !== steer_value || exp_c.aligned !== aligned) begin
          mismatch_count++;
          if (mismatch_count <= ReportLimit) begin
            $display("mismatch exp L=%0d R=%0d S=%0d A=%0b got L=%0d R=%0d S=%0d A=%0b",
                     exp_c.left, exp_c.right, exp_c.steer, exp_c.aligned,
                     left_drive, right_drive, steer_value, aligned);
          end
        end
      end
    end
  end

  // receiver: stall pattern per style, long hold-offs on request
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_off_req != 0) begin
        out_ready <= 1'b0;
        repeat (hold_off_req) @(posedge clk_i);
        hold_off_req = 0;
      end else begin
        rdy_pattern = {rdy_pattern[14:0], rdy_pattern[15]};
        if ($urandom_range(0, 31) == 0) begin
          rdy_pattern = 16'($urandom()) | 16'h0101;
        end
        case (rdy_style)
          RdyPattern: out_ready <= rdy_pattern[0];
          RdyRandom:  out_ready <= ($urandom_range(0, 99) < 60);
          default:    out_ready <= 1'b1;
        endcase
      end
    end
  end

  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    wheel_cfg = '{prop_gain: '0, integ_gain: '0, integ_limit: '0,
                  speed_limit: SpeedLimReset, seek_direction: SeekNone};
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_defaults();
    test_seek_modes();
    test_saturation();
    test_integral_clamp();
    test_floor_shift();
    test_unmapped_writes();
    test_backpressure();
    test_random_phases();
    wait_drained();
    repeat (8) @(posedge clk_i);
    if (mismatch_count == 0 && expected_cmds.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/pha_pkg.sv
rtl/pha_steer_calc.sv
rtl/pi_heading_aligner_top.sv
verif/tb_pi_heading_aligner_top.sv
